@@ sv/recursive_snake_balance_order_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the snake balance order unit
// Each macro samples on the rising edge of clk and is disabled during reset.
// ----------------------------------------------------------------------------
`ifndef RECURSIVE_SNAKE_BALANCE_ORDER_UNIT_ASSERT_SVH
`define RECURSIVE_SNAKE_BALANCE_ORDER_UNIT_ASSERT_SVH

// Condition holds at every edge
`define RSBO_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define RSBO_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent
`define RSBO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/rsbo_pkg.sv @@
// ----------------------------------------------------------------------------
// rsbo_pkg
// Shared types and constants of the snake balance order unit.
// ----------------------------------------------------------------------------
package rsbo_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_START,
        ST_SCAN,
        ST_PLACE,
        ST_COPY,
        ST_POP,
        ST_EMIT_RD,
        ST_EMIT_HOLD
    } state_t;

    // Picks alternate between halves with this period (snake pattern)
    localparam int SnakePeriod = 4;
    localparam int PhaseBits   = $clog2(SnakePeriod);

    typedef logic [PhaseBits-1:0] phase_t;

    // Phase of the first pick of a segment
    localparam phase_t PhaseFirstPick = phase_t'(1);

    // Phases 0 and 1 feed the first half, the others the second half
    function automatic logic snake_first_half(input phase_t phase);
        return phase < phase_t'(SnakePeriod / 2);
    endfunction

endpackage

@@ sv/rsbo_channels.sv @@
// ----------------------------------------------------------------------------
// rsbo channel interfaces
// Valid/ready channels for loaded pairs and for reordered result words.
// ----------------------------------------------------------------------------
interface rsbo_load_if #(
    parameter int WEIGHT_BITS = 16,
    parameter int RANK_BITS   = 8
);
    logic                   valid;
    logic                   ready;
    logic [WEIGHT_BITS-1:0] weight;
    logic [RANK_BITS-1:0]   rank_id;
    logic                   last_entry;

    modport source (output valid, weight, rank_id, last_entry, input ready);
    modport sink   (input valid, weight, rank_id, last_entry, output ready);
endinterface

interface rsbo_result_if #(
    parameter int WEIGHT_BITS = 16,
    parameter int RANK_BITS   = 8
);
    logic                   valid;
    logic                   ready;
    logic [WEIGHT_BITS-1:0] out_weight;
    logic [RANK_BITS-1:0]   out_rank;
    logic                   out_last;

    modport source (output valid, out_weight, out_rank, out_last, input ready);
    modport sink   (input valid, out_weight, out_rank, out_last, output ready);
endinterface

@@ sv/recursive_snake_balance_order_unit.sv @@
// ----------------------------------------------------------------------------
// recursive_snake_balance_order_unit
// Loads a set of weight/rank pairs, reorders it by recursive snake-order
// halving so both halves of every split carry similar weight, then emits it.
//
//   Channel  Role    Word contents                       Moves
//   load     sink    weight, rank_id, last_entry         one pair per word
//   result   source  out_weight, out_rank, out_last      one pair per word
//
// Loading accepts one word per cycle; words beyond MAX_ENTRIES are dropped.
// Reordering: each segment of length L >= 2 takes a start step, L picks that
// each scan it through the single shared compare unit, and a copy-back; the
// store's single read port means each scan reads one entry at a time.
// Emitting reads each word from the store, then holds it until result takes it.
// load.ready is high only while loading; result stalls simply hold the word.
// Reset clears the sequencer, counters and taken mask; no clearing pass.
// ----------------------------------------------------------------------------
`include "recursive_snake_balance_order_unit_assert.svh"

module recursive_snake_balance_order_unit #(
    parameter int MAX_ENTRIES = 16,
    parameter int WEIGHT_BITS = 16,
    parameter int RANK_BITS   = 8
) (
    input logic           clk,
    input logic           rst_n,
    rsbo_load_if.sink     load,
    rsbo_result_if.source result
);

    localparam int CW          = $clog2(MAX_ENTRIES + 1);
    localparam int IW          = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int SW          = WEIGHT_BITS + RANK_BITS;
    localparam int STACK_DEPTH = $clog2(MAX_ENTRIES) + 1;
    localparam int SPW         = $clog2(STACK_DEPTH + 1);
    localparam int SIW         = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // Control registers
    rsbo_pkg::state_t   state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      iss_reg, iss_next;
    logic               pend_reg, pend_next;
    logic [IW-1:0]      pidx_reg, pidx_next;
    logic [IW-1:0]      base_reg, base_next;
    logic [CW-1:0]      len_reg, len_next;
    logic [CW-1:0]      f_reg, f_next;
    logic [CW-1:0]      s_reg, s_next;
    logic [CW-1:0]      pick_reg, pick_next;
    rsbo_pkg::phase_t   phase_reg, phase_next;
    logic [MAX_ENTRIES-1:0] taken_reg, taken_next;
    logic               found_reg, found_next;
    logic [IW-1:0]      best_idx_reg, best_idx_next;
    logic [SPW-1:0]     sp_reg, sp_next;

    // Payload registers
    logic [WEIGHT_BITS-1:0] best_w_reg;
    logic [RANK_BITS-1:0]   best_r_reg;
    logic [IW-1:0]          stk_base_reg [STACK_DEPTH];
    logic [CW-1:0]          stk_len_reg  [STACK_DEPTH];

    // RAM ports
    logic          st_wr_en, st_rd_en, sc_wr_en, sc_rd_en;
    logic [IW-1:0] st_wr_addr, st_rd_addr, sc_wr_addr, sc_rd_addr;
    logic [SW-1:0] st_wr_data, st_rd_data, sc_wr_data, sc_rd_data;

    // Helpers
    logic                   load_fire, result_fire, last_word;
    logic [CW-1:0]          count_after, half, upper;
    logic                   scan_active, cand, first_half, dst_is_f, push_en;
    logic [CW-1:0]          dst;
    logic [IW-1:0]          scan_addr, copy_addr, push_base;
    logic [SPW-1:0]         sp_dec;
    logic [SIW-1:0]         pop_idx;
    logic [WEIGHT_BITS-1:0] rd_w;
    logic [RANK_BITS-1:0]   rd_r;

    assign load_fire   = load.valid && load.ready;
    assign result_fire = result.valid && result.ready;
    assign count_after = (count_reg < CW'(MAX_ENTRIES)) ? count_reg + 1'b1 : count_reg;
    assign half        = len_reg >> 1;
    assign upper       = len_reg - half;
    assign scan_active = iss_reg < len_reg;
    assign scan_addr   = IW'((CW + 1)'(base_reg) + (CW + 1)'(iss_reg));
    assign copy_addr   = IW'((CW + 1)'(base_reg) + (CW + 1)'(pidx_reg));
    assign push_base   = IW'((CW + 1)'(base_reg) + (CW + 1)'(half));
    assign sp_dec      = sp_reg - 1'b1;
    assign pop_idx     = sp_dec[SIW-1:0];
    assign last_word   = ((CW + 1)'(iss_reg) + 1'b1) == (CW + 1)'(count_reg);
    assign rd_w        = st_rd_data[SW-1:RANK_BITS];
    assign rd_r        = st_rd_data[RANK_BITS-1:0];

    // Shared compare unit: first untaken entry, or an untaken one heavier than the best so far
    assign cand = (state_reg == rsbo_pkg::ST_SCAN) && pend_reg && !taken_reg[pidx_reg]
                  && (!found_reg || (rd_w > best_w_reg));

    // Snake destination with spill into the other half when full
    assign first_half = rsbo_pkg::snake_first_half(phase_reg);
    always_comb
    begin
        if (first_half)
        begin
            dst_is_f = f_reg < half;
        end
        else
        begin
            dst_is_f = !(s_reg < len_reg);
        end
        dst = dst_is_f ? f_reg : s_reg;
    end

    assign push_en = (state_reg == rsbo_pkg::ST_COPY) && !scan_active;

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rsbo_pkg::ST_LOAD:
            begin
                if (load_fire && load.last_entry)
                begin
                    state_next = rsbo_pkg::ST_START;
                end
            end
            rsbo_pkg::ST_START:
            begin
                state_next = (len_reg <= CW'(1)) ? rsbo_pkg::ST_POP : rsbo_pkg::ST_SCAN;
            end
            rsbo_pkg::ST_SCAN:
            begin
                if (!scan_active)
                begin
                    state_next = rsbo_pkg::ST_PLACE;
                end
            end
            rsbo_pkg::ST_PLACE:
            begin
                state_next = ((pick_reg + 1'b1) == len_reg) ? rsbo_pkg::ST_COPY
                                                            : rsbo_pkg::ST_SCAN;
            end
            rsbo_pkg::ST_COPY:
            begin
                if (!scan_active)
                begin
                    state_next = rsbo_pkg::ST_START;
                end
            end
            rsbo_pkg::ST_POP:
            begin
                state_next = (sp_reg == '0) ? rsbo_pkg::ST_EMIT_RD : rsbo_pkg::ST_START;
            end
            rsbo_pkg::ST_EMIT_RD:
            begin
                state_next = rsbo_pkg::ST_EMIT_HOLD;
            end
            rsbo_pkg::ST_EMIT_HOLD:
            begin
                if (result_fire)
                begin
                    state_next = last_word ? rsbo_pkg::ST_LOAD : rsbo_pkg::ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = rsbo_pkg::ST_LOAD;
            end
        endcase
    end

    // Outputs and RAM controls
    always_comb
    begin
        load.ready   = (state_reg == rsbo_pkg::ST_LOAD);
        result.valid = (state_reg == rsbo_pkg::ST_EMIT_HOLD);
        st_wr_en     = 1'b0;
        st_wr_addr   = count_reg[IW-1:0];
        st_wr_data   = {load.weight, load.rank_id};
        st_rd_en     = 1'b0;
        st_rd_addr   = scan_addr;
        sc_wr_en     = 1'b0;
        sc_wr_addr   = dst[IW-1:0];
        sc_wr_data   = {best_w_reg, best_r_reg};
        sc_rd_en     = 1'b0;
        sc_rd_addr   = iss_reg[IW-1:0];
        unique case (state_reg)
            rsbo_pkg::ST_LOAD:
            begin
                st_wr_en = load_fire && (count_reg < CW'(MAX_ENTRIES));
            end
            rsbo_pkg::ST_SCAN:
            begin
                st_rd_en = scan_active;
            end
            rsbo_pkg::ST_PLACE:
            begin
                sc_wr_en = 1'b1;
            end
            rsbo_pkg::ST_COPY:
            begin
                sc_rd_en   = scan_active;
                st_wr_en   = pend_reg;
                st_wr_addr = copy_addr;
                st_wr_data = sc_rd_data;
            end
            rsbo_pkg::ST_EMIT_RD:
            begin
                st_rd_en   = 1'b1;
                st_rd_addr = iss_reg[IW-1:0];
            end
            default:
            begin
            end
        endcase
    end

    assign result.out_weight = rd_w;
    assign result.out_rank   = rd_r;
    assign result.out_last   = last_word;

    // Datapath next values
    always_comb
    begin
        count_next    = count_reg;
        iss_next      = iss_reg;
        pend_next     = 1'b0;
        pidx_next     = iss_reg[IW-1:0];
        base_next     = base_reg;
        len_next      = len_reg;
        f_next        = f_reg;
        s_next        = s_reg;
        pick_next     = pick_reg;
        phase_next    = phase_reg;
        taken_next    = taken_reg;
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        sp_next       = sp_reg;
        unique case (state_reg)
            rsbo_pkg::ST_LOAD:
            begin
                if (load_fire)
                begin
                    count_next = count_after;
                    if (load.last_entry)
                    begin
                        base_next = '0;
                        len_next  = count_after;
                    end
                end
            end
            rsbo_pkg::ST_START:
            begin
                iss_next   = '0;
                found_next = 1'b0;
                taken_next = '0;
                f_next     = '0;
                s_next     = half;
                pick_next  = '0;
                phase_next = rsbo_pkg::PhaseFirstPick;
            end
            rsbo_pkg::ST_SCAN:
            begin
                pend_next = scan_active;
                if (scan_active)
                begin
                    iss_next = iss_reg + 1'b1;
                end
                if (cand)
                begin
                    found_next    = 1'b1;
                    best_idx_next = pidx_reg;
                end
            end
            rsbo_pkg::ST_PLACE:
            begin
                taken_next[best_idx_reg] = 1'b1;
                if (dst_is_f)
                begin
                    f_next = f_reg + 1'b1;
                end
                else
                begin
                    s_next = s_reg + 1'b1;
                end
                pick_next  = pick_reg + 1'b1;
                phase_next = phase_reg + 1'b1;
                iss_next   = '0;
                found_next = 1'b0;
            end
            rsbo_pkg::ST_COPY:
            begin
                pend_next = scan_active;
                if (scan_active)
                begin
                    iss_next = iss_reg + 1'b1;
                end
                else
                begin
                    // second half waits on the stack, first half goes next
                    len_next = half;
                    sp_next  = sp_reg + 1'b1;
                end
            end
            rsbo_pkg::ST_POP:
            begin
                if (sp_reg != '0)
                begin
                    base_next = stk_base_reg[pop_idx];
                    len_next  = stk_len_reg[pop_idx];
                    sp_next   = sp_dec;
                end
                else
                begin
                    iss_next = '0;
                end
            end
            rsbo_pkg::ST_EMIT_HOLD:
            begin
                if (result_fire)
                begin
                    if (last_word)
                    begin
                        count_next = '0;
                    end
                    else
                    begin
                        iss_next = iss_reg + 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= rsbo_pkg::ST_LOAD;
            count_reg    <= '0;
            iss_reg      <= '0;
            pend_reg     <= 1'b0;
            pidx_reg     <= '0;
            base_reg     <= '0;
            len_reg      <= '0;
            f_reg        <= '0;
            s_reg        <= '0;
            pick_reg     <= '0;
            phase_reg    <= rsbo_pkg::PhaseFirstPick;
            taken_reg    <= '0;
            found_reg    <= 1'b0;
            best_idx_reg <= '0;
            sp_reg       <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            iss_reg      <= iss_next;
            pend_reg     <= pend_next;
            pidx_reg     <= pidx_next;
            base_reg     <= base_next;
            len_reg      <= len_next;
            f_reg        <= f_next;
            s_reg        <= s_next;
            pick_reg     <= pick_next;
            phase_reg    <= phase_next;
            taken_reg    <= taken_next;
            found_reg    <= found_next;
            best_idx_reg <= best_idx_next;
            sp_reg       <= sp_next;
        end
    end

    // Best candidate and segment stack payload
    always_ff @(posedge clk)
    begin
        if (cand)
        begin
            best_w_reg <= rd_w;
            best_r_reg <= rd_r;
        end
        if (push_en)
        begin
            stk_base_reg[sp_reg[SIW-1:0]] <= push_base;
            stk_len_reg[sp_reg[SIW-1:0]]  <= upper;
        end
    end

    // Loaded set
    rsbo_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_ENTRIES),
        .AW    (IW)
    ) u_store (
        .clk     (clk),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data),
        .rd_en   (st_rd_en),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data)
    );

    // Halves under construction
    rsbo_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_ENTRIES),
        .AW    (IW)
    ) u_scratch (
        .clk     (clk),
        .wr_en   (sc_wr_en),
        .wr_addr (sc_wr_addr),
        .wr_data (sc_wr_data),
        .rd_en   (sc_rd_en),
        .rd_addr (sc_rd_addr),
        .rd_data (sc_rd_data)
    );

    // Checks
    `RSBO_ASSERT_ALWAYS(a_stack_bound, sp_reg <= SPW'(STACK_DEPTH), "segment stack overflow")
    `RSBO_ASSERT_IMPL(a_place_found, state_reg == rsbo_pkg::ST_PLACE, found_reg, "pick without candidate")
    `RSBO_ASSERT_IMPL(a_taken_picks, state_reg == rsbo_pkg::ST_SCAN, $countones(taken_reg) == int'(pick_reg), "taken mask out of step with picks")
    `RSBO_ASSERT_ALWAYS(a_one_side, !(load.ready && result.valid), "loading while emitting")
    `RSBO_ASSERT_NEXT(a_set_done, result.valid && result.ready && result.out_last, state_reg == rsbo_pkg::ST_LOAD && count_reg == '0, "set not closed after last word")

endmodule

@@ sv/rsbo_ram.sv @@
// ----------------------------------------------------------------------------
// rsbo_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rsbo_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, holds while idle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
